[design/i2cm_pkg.sv]
// shared types and codes for the i2c random byte access master
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int unsigned QTR_W = 10;
    localparam int unsigned TICK_W = 11;
    localparam logic [QTR_W-1:0] QTR_RESET = 10'd5;

    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
    localparam logic [7:0] READ_FAIL    = 8'hFF;

    // stages of the byte sequence within one transaction
    localparam logic [1:0] STG_DEVICE   = 2'd0;
    localparam logic [1:0] STG_REGISTER = 2'd1;
    localparam logic [1:0] STG_DATA     = 2'd2;
    localparam logic [1:0] STG_READ_DEV = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
        logic [7:0] read_byte;
    } t_out;

endpackage

[design/i2cm_seq.sv]
// bus sequencer: advances one step per beat and forms the line levels
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  i2cm_pkg::t_in                 i_item,
    input  logic [i2cm_pkg::QTR_W-1:0]    i_quarter,
    output i2cm_pkg::t_out                o_res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START, PH_WB_LOW, PH_WB_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
        PH_ACK_TAIL, PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_D, PH_RB_LOW,
        PH_RB_HIGH, PH_NA_LOW, PH_NA_HIGH, PH_SP_A, PH_SP_B, PH_SP_C
    } t_phase;

    t_phase                         r_phase,   n_phase;
    logic [3:0]                     r_bit,     n_bit;
    logic [7:0]                     r_shift,   n_shift;
    logic [i2cm_pkg::TICK_W-1:0]    r_tick,    n_tick;
    logic [7:0]                     r_dev,     n_dev;
    logic [7:0]                     r_reg,     n_reg;
    logic [7:0]                     r_data,    n_data;
    logic                           r_is_read, n_is_read;
    logic                           r_nack,    n_nack;
    logic [7:0]                     r_result,  n_result;
    logic [1:0]                     r_stage,   n_stage;

    logic [i2cm_pkg::QTR_W-1:0]     q_eff;
    logic [i2cm_pkg::TICK_W-1:0]    seg_len;
    logic [i2cm_pkg::TICK_W-1:0]    tick_inc;
    logic                           short_seg;
    logic                           is_cmd;
    logic                           done;
    logic                           scl_low;
    logic                           sda_low;

    assign q_eff = (i_quarter == '0) ? i2cm_pkg::QTR_W'(1) : i_quarter;
    assign short_seg = (r_phase == PH_START) || (r_phase == PH_RS_A) ||
                       (r_phase == PH_RS_D)  || (r_phase == PH_SP_B);
    assign seg_len = short_seg ? {1'b0, q_eff} : {q_eff, 1'b0};
    assign tick_inc = r_tick + i2cm_pkg::TICK_W'(1);
    assign is_cmd = (i_item.op == i2cm_pkg::OP_WRITE) ||
                    (i_item.op == i2cm_pkg::OP_READ);

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_tick    = r_tick;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_is_read = r_is_read;
        n_nack    = r_nack;
        n_result  = r_result;
        n_stage   = r_stage;
        done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (is_cmd) begin
                n_dev     = i_item.device_addr;
                n_reg     = i_item.reg_addr;
                n_data    = i_item.write_data;
                n_is_read = (i_item.op == i2cm_pkg::OP_READ);
                n_nack    = 1'b0;
                if (i_item.op == i2cm_pkg::OP_READ) begin
                    n_result = i2cm_pkg::READ_FAIL;
                end
                n_tick  = '0;
                n_bit   = '0;
                n_shift = '0;
                n_stage = i2cm_pkg::STG_DEVICE;
                n_phase = PH_START;
            end
        end else if (tick_inc >= seg_len) begin
            n_tick = '0;
            unique case (r_phase)
                PH_START: begin
                    n_shift = r_dev & i2cm_pkg::ADDR_WR_MASK;
                    n_bit   = '0;
                    n_stage = i2cm_pkg::STG_DEVICE;
                    n_phase = PH_WB_LOW;
                end
                PH_WB_LOW:   n_phase = PH_WB_HIGH;
                PH_WB_HIGH: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    n_phase = (n_bit >= 4'd8) ? PH_ACK_LOW : PH_WB_LOW;
                end
                PH_ACK_LOW:  n_phase = PH_ACK_HIGH;
                PH_ACK_HIGH: begin
                    if (i_item.sda_in) begin
                        n_nack = 1'b1;
                    end
                    n_phase = PH_ACK_TAIL;
                end
                PH_ACK_TAIL: begin
                    if (r_nack) begin
                        n_phase = PH_SP_A;
                    end else begin
                        unique case (r_stage)
                            i2cm_pkg::STG_DEVICE: begin
                                n_shift = r_reg;
                                n_bit   = '0;
                                n_stage = i2cm_pkg::STG_REGISTER;
                                n_phase = PH_WB_LOW;
                            end
                            i2cm_pkg::STG_REGISTER: begin
                                if (r_is_read) begin
                                    n_phase = PH_RS_A;
                                end else begin
                                    n_shift = r_data;
                                    n_bit   = '0;
                                    n_stage = i2cm_pkg::STG_DATA;
                                    n_phase = PH_WB_LOW;
                                end
                            end
                            i2cm_pkg::STG_DATA: n_phase = PH_SP_A;
                            default: begin
                                n_shift = '0;
                                n_bit   = '0;
                                n_phase = PH_RB_LOW;
                            end
                        endcase
                    end
                end
                PH_RS_A: n_phase = PH_RS_B;
                PH_RS_B: n_phase = PH_RS_C;
                PH_RS_C: n_phase = PH_RS_D;
                PH_RS_D: begin
                    n_shift = r_dev | i2cm_pkg::ADDR_RD_BIT;
                    n_bit   = '0;
                    n_stage = i2cm_pkg::STG_READ_DEV;
                    n_phase = PH_WB_LOW;
                end
                PH_RB_LOW:  n_phase = PH_RB_HIGH;
                PH_RB_HIGH: begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_bit   = r_bit + 4'd1;
                    if (n_bit >= 4'd8) begin
                        n_result = n_shift;
                        n_phase  = PH_NA_LOW;
                    end else begin
                        n_phase = PH_RB_LOW;
                    end
                end
                PH_NA_LOW:  n_phase = PH_NA_HIGH;
                PH_NA_HIGH: n_phase = PH_SP_A;
                PH_SP_A:    n_phase = PH_SP_B;
                PH_SP_B:    n_phase = PH_SP_C;
                PH_SP_C: begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end else begin
            n_tick = tick_inc;
        end
    end

    // line levels follow the phase after the step
    always_comb begin
        unique case (n_phase)
            PH_START, PH_RS_D, PH_SP_B: begin
                scl_low = 1'b0;
                sda_low = 1'b1;
            end
            PH_WB_LOW: begin
                scl_low = 1'b1;
                sda_low = ~n_shift[7];
            end
            PH_WB_HIGH: begin
                scl_low = 1'b0;
                sda_low = ~n_shift[7];
            end
            PH_ACK_LOW, PH_RS_A, PH_RS_B, PH_RB_LOW, PH_NA_LOW: begin
                scl_low = 1'b1;
                sda_low = 1'b0;
            end
            PH_SP_A: begin
                scl_low = 1'b1;
                sda_low = 1'b1;
            end
            default: begin
                scl_low = 1'b0;
                sda_low = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res.scl_drive_low = scl_low;
        o_res.sda_drive_low = sda_low;
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.done_res      = done;
        o_res.nack_seen     = n_nack;
        o_res.read_byte     = n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= '0;
            r_shift   <= '0;
            r_tick    <= '0;
            r_dev     <= '0;
            r_reg     <= '0;
            r_data    <= '0;
            r_is_read <= 1'b0;
            r_nack    <= 1'b0;
            r_result  <= i2cm_pkg::READ_FAIL;
            r_stage   <= i2cm_pkg::STG_DEVICE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_tick    <= n_tick;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_is_read <= n_is_read;
            r_nack    <= n_nack;
            r_result  <= n_result;
            r_stage   <= n_stage;
        end
    end

endmodule

[design/i2c_master_random_byte_access.sv]
// top level: input register, bus sequencer and result register
// Open-drain I2C master for one random byte write or read per command.
// Input channel (i_in_valid / o_in_ready, i_in_data) carries one beat per
// tick or command: op 0 advances time by one tick and presents the sampled
// SDA level, op 1 starts a write, op 2 starts a read. Commands arriving
// while a transaction runs are taken as ticks.
// Output channel (o_out_valid / i_out_ready, o_out_data) returns exactly one
// beat per input beat: the SCL/SDA pull-low levels, busy, done pulse, nack
// flag and the last read byte, all as they stand after that input beat.
// An accepted beat waits in the input register, passes through the combinational
// sequencer step and is captured in the result register; throughput is one
// beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat; o_in_ready then drops until the result moves.
// Reset (i_rst_n low, synchronous) empties both registers, returns the
// sequencer to idle with read byte 0xFF, and sets the quarter period to 5.
// i_cfg_we writes the quarter period in ticks; write it only while idle.
`timescale 1ns / 1ps

module i2c_master_random_byte_access (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  i2cm_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output i2cm_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [i2cm_pkg::QTR_W-1:0]    i_cfg_data
);

    logic                           r_in_valid;
    i2cm_pkg::t_in                  r_in;
    logic                           r_out_valid;
    i2cm_pkg::t_out                 r_out;
    logic [i2cm_pkg::QTR_W-1:0]     r_quarter;
    logic                           advance;
    i2cm_pkg::t_out                 step_res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    i2cm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_item    (r_in),
        .i_quarter (r_quarter),
        .o_res     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter <= i2cm_pkg::QTR_RESET;
        end else if (i_cfg_we) begin
            r_quarter <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[test/i2cm_bus_checker.sv]
// checker for the i2c random byte master: predicts each result beat and compares it
`timescale 1ns / 1ps

module i2cm_bus_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  i2cm_pkg::t_in               i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  i2cm_pkg::t_out              i_out_data,
    input  logic                        i_cfg_we,
    input  logic [i2cm_pkg::QTR_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START, SEQ_WB_LOW, SEQ_WB_HIGH, SEQ_ACK_LOW, SEQ_ACK_HIGH,
        SEQ_ACK_TAIL, SEQ_RS_A, SEQ_RS_B, SEQ_RS_C, SEQ_RS_D, SEQ_RB_LOW,
        SEQ_RB_HIGH, SEQ_NA_LOW, SEQ_NA_HIGH, SEQ_SP_A, SEQ_SP_B, SEQ_SP_C
    } t_seq;

    t_seq                        seq;
    logic [3:0]                  bit_cnt;
    logic [7:0]                  shreg;
    logic [i2cm_pkg::TICK_W-1:0] tick_cnt;
    logic [7:0]                  dev_hold;
    logic [7:0]                  reg_hold;
    logic [7:0]                  data_hold;
    logic                        rd_cmd;
    logic                        nack_flag;
    logic [7:0]                  last_read;
    logic [1:0]                  stage;
    logic [i2cm_pkg::QTR_W-1:0]  quarter;
    i2cm_pkg::t_out              predicted_results[$];

    function automatic logic [i2cm_pkg::TICK_W-1:0] segment_ticks(t_seq s);
        logic [i2cm_pkg::TICK_W-1:0] q;
        q = {1'b0, quarter};
        if (quarter == '0) q = i2cm_pkg::TICK_W'(1);
        if (s == SEQ_START || s == SEQ_RS_A || s == SEQ_RS_D || s == SEQ_SP_B) return q;
        return q << 1;
    endfunction

    function void load_byte(logic [7:0] value, logic [1:0] stg);
        shreg = value;
        bit_cnt = '0;
        stage = stg;
        seq = SEQ_WB_LOW;
    endfunction

    function void close_segment(logic sda);
        case (seq)
            SEQ_START: load_byte(dev_hold & i2cm_pkg::ADDR_WR_MASK, i2cm_pkg::STG_DEVICE);
            SEQ_WB_LOW: seq = SEQ_WB_HIGH;
            SEQ_WB_HIGH: begin
                shreg = shreg << 1;
                bit_cnt = bit_cnt + 4'd1;
                seq = (bit_cnt >= 4'd8) ? SEQ_ACK_LOW : SEQ_WB_LOW;
            end
            SEQ_ACK_LOW: seq = SEQ_ACK_HIGH;
            SEQ_ACK_HIGH: begin
                if (sda) nack_flag = 1'b1;
                seq = SEQ_ACK_TAIL;
            end
            SEQ_ACK_TAIL: begin
                // a missing acknowledge skips whatever bytes are left
                if (nack_flag) begin
                    seq = SEQ_SP_A;
                end else begin
                    case (stage)
                        i2cm_pkg::STG_DEVICE: load_byte(reg_hold, i2cm_pkg::STG_REGISTER);
                        i2cm_pkg::STG_REGISTER: begin
                            if (rd_cmd) seq = SEQ_RS_A;
                            else load_byte(data_hold, i2cm_pkg::STG_DATA);
                        end
                        i2cm_pkg::STG_DATA: seq = SEQ_SP_A;
                        default: begin
                            shreg = '0;
                            bit_cnt = '0;
                            seq = SEQ_RB_LOW;
                        end
                    endcase
                end
            end
            SEQ_RS_A: seq = SEQ_RS_B;
            SEQ_RS_B: seq = SEQ_RS_C;
            SEQ_RS_C: seq = SEQ_RS_D;
            SEQ_RS_D: load_byte(dev_hold | i2cm_pkg::ADDR_RD_BIT, i2cm_pkg::STG_READ_DEV);
            SEQ_RB_LOW: seq = SEQ_RB_HIGH;
            SEQ_RB_HIGH: begin
                shreg = {shreg[6:0], sda};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    last_read = shreg;
                    seq = SEQ_NA_LOW;
                end else begin
                    seq = SEQ_RB_LOW;
                end
            end
            SEQ_NA_LOW: seq = SEQ_NA_HIGH;
            SEQ_NA_HIGH: seq = SEQ_SP_A;
            SEQ_SP_A: seq = SEQ_SP_B;
            SEQ_SP_B: seq = SEQ_SP_C;
            default: seq = SEQ_IDLE;
        endcase
    endfunction

    function i2cm_pkg::t_out advance_master(i2cm_pkg::t_in beat);
        i2cm_pkg::t_out r;
        logic finished;
        finished = 1'b0;
        if (seq == SEQ_IDLE &&
            (beat.op == i2cm_pkg::OP_WRITE || beat.op == i2cm_pkg::OP_READ)) begin
            // command beat: latch fields, no time passes
            dev_hold = beat.device_addr;
            reg_hold = beat.reg_addr;
            data_hold = beat.write_data;
            rd_cmd = (beat.op == i2cm_pkg::OP_READ);
            nack_flag = 1'b0;
            if (rd_cmd) last_read = i2cm_pkg::READ_FAIL;
            tick_cnt = '0;
            bit_cnt = '0;
            shreg = '0;
            stage = i2cm_pkg::STG_DEVICE;
            seq = SEQ_START;
        end else if (seq != SEQ_IDLE) begin
            tick_cnt = tick_cnt + i2cm_pkg::TICK_W'(1);
            if (tick_cnt >= segment_ticks(seq)) begin
                tick_cnt = '0;
                if (seq == SEQ_SP_C) begin
                    seq = SEQ_IDLE;
                    finished = 1'b1;
                end else begin
                    close_segment(beat.sda_in);
                end
            end
        end
        r = '0;
        case (seq)
            SEQ_START, SEQ_RS_D, SEQ_SP_B: r.sda_drive_low = 1'b1;
            SEQ_WB_LOW: begin
                r.scl_drive_low = 1'b1;
                r.sda_drive_low = ~shreg[7];
            end
            SEQ_WB_HIGH: r.sda_drive_low = ~shreg[7];
            SEQ_ACK_LOW, SEQ_RS_A, SEQ_RS_B, SEQ_RB_LOW, SEQ_NA_LOW: r.scl_drive_low = 1'b1;
            SEQ_SP_A: begin
                r.scl_drive_low = 1'b1;
                r.sda_drive_low = 1'b1;
            end
            default: ;
        endcase
        r.busy_res = (seq != SEQ_IDLE);
        r.done_res = finished;
        r.nack_seen = nack_flag;
        r.read_byte = last_read;
        return r;
    endfunction

    function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : track
        int errs;
        i2cm_pkg::t_out want;
        errs = 0;
        if (!i_rst_n) begin
            quarter = i2cm_pkg::QTR_RESET;
            seq = SEQ_IDLE;
            bit_cnt = '0;
            shreg = '0;
            tick_cnt = '0;
            dev_hold = '0;
            reg_hold = '0;
            data_hold = '0;
            rd_cmd = 1'b0;
            nack_flag = 1'b0;
            last_read = i2cm_pkg::READ_FAIL;
            stage = i2cm_pkg::STG_DEVICE;
            predicted_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) quarter = i_cfg_data;
            // result beat first: it always belongs to an older input beat
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, i_out_data);
                    errs++;
                end else begin
                    want = predicted_results.pop_front();
                    errs += field_diff("scl_drive_low", 8'(want.scl_drive_low),
                                       8'(i_out_data.scl_drive_low));
                    errs += field_diff("sda_drive_low", 8'(want.sda_drive_low),
                                       8'(i_out_data.sda_drive_low));
                    errs += field_diff("busy_res", 8'(want.busy_res),
                                       8'(i_out_data.busy_res));
                    errs += field_diff("done_res", 8'(want.done_res),
                                       8'(i_out_data.done_res));
                    errs += field_diff("nack_seen", 8'(want.nack_seen),
                                       8'(i_out_data.nack_seen));
                    errs += field_diff("read_byte", want.read_byte, i_out_data.read_byte);
                end
            end
            if (i_in_valid && i_in_ready) predicted_results.push_back(advance_master(i_in_data));
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= predicted_results.size();
    end

endmodule

[test/i2c_master_random_byte_access_tb.sv]
// testbench top for the i2c random byte master: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module i2c_master_random_byte_access_tb;

    // op code the block treats as a plain tick
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    i2cm_pkg::t_in              in_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    i2cm_pkg::t_out             out_data;
    logic                       cfg_we = 1'b0;
    logic [i2cm_pkg::QTR_W-1:0] cfg_data = i2cm_pkg::QTR_RESET;

    int                         fail_count;
    int                         pending;
    int                         in_count;
    int                         out_count;
    int                         item_count = 0;
    logic                       last_busy;
    logic                       gaps_on = 1'b1;
    logic                       stall_on = 1'b1;
    logic                       pause_once = 1'b1;
    logic [i2cm_pkg::QTR_W-1:0] cur_q = i2cm_pkg::QTR_RESET;

    always #5 clk = ~clk;

    i2c_master_random_byte_access uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    i2cm_bus_checker bus_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            in_count <= 0;
            out_count <= 0;
            last_busy <= 1'b0;
        end else begin
            if (in_valid && in_ready) in_count <= in_count + 1;
            if (out_valid && out_ready) begin
                out_count <= out_count + 1;
                last_busy <= out_data.busy_res;
            end
        end
    end

    // receiver: random stall, when enabled, before every result beat
    initial begin
        int stall;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            stall = stall_on ? $urandom_range(0, 16) : 0;
            repeat (stall) begin
                out_ready <= 1'b0;
                @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input i2cm_pkg::t_in beat);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        item_count++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (in_count != out_count) @(negedge clk);
    endtask

    function automatic i2cm_pkg::t_in make_tick(logic sda);
        i2cm_pkg::t_in b;
        b.op = i2cm_pkg::OP_TICK;
        b.device_addr = 8'($urandom_range(0, 255));
        b.reg_addr = 8'($urandom_range(0, 255));
        b.write_data = 8'($urandom_range(0, 255));
        b.sda_in = sda;
        return b;
    endfunction

    function automatic i2cm_pkg::t_in make_cmd(logic [1:0] op, logic [7:0] dev,
                                               logic [7:0] rg, logic [7:0] dat);
        i2cm_pkg::t_in b;
        b.op = op;
        b.device_addr = dev;
        b.reg_addr = rg;
        b.write_data = dat;
        b.sda_in = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // make sure the sequencer has finished before touching the quarter period
    task automatic settle_bus();
        drain_results();
        while (last_busy) begin
            send_item(make_tick(1'($urandom_range(0, 1))));
            drain_results();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_quarter(input logic [i2cm_pkg::QTR_W-1:0] value);
        settle_bus();
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_q = value;
    endtask

    // one command plus the ticks it needs; the slave answers per plan
    // (plan bit set = no acknowledge on that byte), read bits come from rd_val, sda elsewhere is random
    task automatic run_transaction(input i2cm_pkg::t_in cmd, input logic [2:0] nack_plan,
                                   input logic [7:0] rd_val, input int noise);
        int qe, a0, a1, a2, rb_base, span, t, idx;
        logic rd;
        logic sda;
        i2cm_pkg::t_in beat;
        rd = (cmd.op == i2cm_pkg::OP_READ);
        qe = (cur_q == '0) ? 1 : int'(cur_q);
        a0 = 37 * qe;
        a1 = 75 * qe;
        a2 = (rd ? 119 : 113) * qe;
        rb_base = 121 * qe;
        if (nack_plan[0]) span = a0 + 7 * qe;
        else if (nack_plan[1]) span = a1 + 7 * qe;
        else if (nack_plan[2]) span = a2 + 7 * qe;
        else span = (rd ? 162 : 120) * qe;
        send_item(cmd);
        for (t = 1; t <= span; t++) begin
            sda = 1'($urandom_range(0, 1));
            if (t == a0) begin
                sda = nack_plan[0];
            end else if (t == a1) begin
                sda = nack_plan[1];
            end else if (t == a2) begin
                sda = nack_plan[2];
            end else if (rd && t > rb_base && t <= rb_base + 32 * qe
                         && (t - rb_base) % (4 * qe) == 0) begin
                idx = (t - rb_base) / (4 * qe);
                sda = rd_val[8 - idx];
            end
            beat = make_tick(sda);
            // commands and the spare op mid-transaction only count as ticks
            if (noise > 0 && $urandom_range(0, noise - 1) == 0)
                beat.op = 2'($urandom_range(1, 3));
            if (pause_once && t == 10) begin
                pause_once = 1'b0;
                drain_results();
            end
            send_item(beat);
        end
    endtask

    initial begin
        i2cm_pkg::t_in beat;
        logic [2:0] plan;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle behaviour and a write refused at the device byte, at the reset quarter period
        send_item(make_tick(1'b0));
        send_item(make_tick(1'b1));
        beat = make_tick(1'b1);
        beat.op = OP_SPARE;
        send_item(beat);
        run_transaction(make_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 8'h00, 8'hFF), 3'b001, 8'h00, 0);

        set_quarter(10'd1);
        run_transaction(make_cmd(i2cm_pkg::OP_READ, 8'hFF, 8'h00, 8'hFF), 3'b000, 8'hA5, 16);

        // zero quarter period behaves as one
        set_quarter('0);
        run_transaction(make_cmd(i2cm_pkg::OP_READ, 8'hA0, 8'h7F, 8'h80), 3'b010, 8'h00, 0);

        while (item_count < 860) begin
            if ($urandom_range(0, 2) == 0)
                set_quarter(i2cm_pkg::QTR_W'($urandom_range(0, 1)));
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3)) begin
                beat = make_tick(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0) beat.op = OP_SPARE;
                send_item(beat);
            end
            if ($urandom_range(0, 7) == 0) drain_results();
            plan = '0;
            for (int k = 0; k < 3; k++)
                if ($urandom_range(0, 7) == 0) plan[k] = 1'b1;
            run_transaction(make_cmd($urandom_range(0, 1) ? i2cm_pkg::OP_READ
                                                          : i2cm_pkg::OP_WRITE,
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255))),
                            plan, 8'($urandom_range(0, 255)), 24);
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
